// ===== rtl/core/sbft_pkg.sv =====
// ----------------------------------------------------------------------------
// sbft_pkg: shared types and constants of the sorted byte frequency table
// Holds the list size, the count width, the item types and the command and
// status records that pass between the top level and the cells.
// ----------------------------------------------------------------------------
package sbft_pkg;

  localparam int NUM_SYMBOLS = 256;
  localparam int COUNT_WIDTH = 24;
  localparam int IDX_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int N_W = $clog2(NUM_SYMBOLS + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef logic [7:0] sym_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [N_W-1:0] fill_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_BUMP,
    OP_INSERT
  } op_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] symbol_in;
    logic [7:0] read_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  symbol_out;
    logic [23:0] count_out;
    logic [7:0]  rank_out;
    logic [8:0]  distinct_out;
    logic        entry_valid;
  } result_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    op_t    op;
    sym_t   sym;
    count_t c;
    count_t cnew;
  } cell_cmd_t;

  // Flags that a cell reports about itself.
  typedef struct packed {
    logic match;
    logic run_end;
    logic ins_here;
  } cell_stat_t;

  function automatic logic [23:0] to_count_out(input count_t x);
    logic [31:0] t;
    t = 32'(x);
    return t[23:0];
  endfunction

endpackage

// ===== rtl/core/sbft_cell.sv =====
// ----------------------------------------------------------------------------
// sbft_cell: one entry of the sorted list
// Holds a symbol and its count, compares them against the broadcast command
// and takes its new contents from itself, a neighbor or the command.
// ----------------------------------------------------------------------------
module sbft_cell (
  input  logic               clk,
  input  sbft_pkg::cell_cmd_t cmd,
  input  logic               occ,
  input  logic               slot,
  input  logic               at_or_past,
  input  logic               left_occ,
  input  sbft_pkg::sym_t     left_sym,
  input  sbft_pkg::count_t   left_cnt,
  input  logic               right_occ,
  input  sbft_pkg::sym_t     right_sym,
  input  sbft_pkg::count_t   right_cnt,
  output sbft_pkg::sym_t     sym,
  output sbft_pkg::count_t   cnt,
  output sbft_pkg::cell_stat_t stat
);
  import sbft_pkg::*;

  logic in_run;
  logic left_gt1;
  logic shift_right;

  always_comb begin
    in_run = occ && (cnt == cmd.c);
    left_gt1 = left_occ && (left_cnt > COUNT_ONE);
    shift_right = slot && left_gt1;
    stat.match = occ && (sym == cmd.sym);
    // The last entry of the run that shares the bumped count receives it.
    stat.run_end = in_run && !(right_occ && (right_cnt == cmd.c));
    // A new symbol goes before the first count above one, or at the end.
    stat.ins_here = slot && (!occ || (cnt > COUNT_ONE)) && !left_gt1;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BUMP: begin
        if (stat.run_end) begin
          sym <= cmd.sym;
          cnt <= cmd.cnew;
        end else if (in_run && at_or_past) begin
          sym <= right_sym;
          cnt <= right_cnt;
        end
      end
      OP_INSERT: begin
        if (stat.ins_here) begin
          sym <= cmd.sym;
          cnt <= COUNT_ONE;
        end else if (shift_right) begin
          sym <= left_sym;
          cnt <= left_cnt;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/sbft_select.sv =====
// ----------------------------------------------------------------------------
// sbft_select: one-hot selector over the cell row
// Folds a one-hot flag vector into the flagged cell's symbol, count and
// position with an AND-OR tree.
// ----------------------------------------------------------------------------
module sbft_select (
  input  logic [sbft_pkg::NUM_SYMBOLS-1:0] hot,
  input  sbft_pkg::sym_t                   syms [sbft_pkg::NUM_SYMBOLS],
  input  sbft_pkg::count_t                 cnts [sbft_pkg::NUM_SYMBOLS],
  output sbft_pkg::sym_t                   sym_sel,
  output sbft_pkg::count_t                 cnt_sel,
  output sbft_pkg::idx_t                   idx_sel
);
  import sbft_pkg::*;

  always_comb begin
    sym_sel = '0;
    cnt_sel = '0;
    idx_sel = '0;
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (hot[i]) begin
        sym_sel = sym_sel | syms[i];
        cnt_sel = cnt_sel | cnts[i];
        idx_sel = idx_sel | IDX_W'(i);
      end
    end
  end

endmodule

// ===== rtl/core/sorted_byte_frequency_table.sv =====
// ----------------------------------------------------------------------------
// sorted_byte_frequency_table: byte counter with a count-sorted symbol list
// A row of cells keeps the distinct symbols in ascending count order; a
// sequencer matches, reduces and then lets every cell shift in one step.
// ----------------------------------------------------------------------------
// Timing: a read shows its result from the match state; a count shows it
// from the apply state, or from the reduce state when the count is saturated
// or the list is full. A new item is taken in the cycle its predecessor's
// result shows, never before the block is through with the last one. Reset
// clears the distinct count, the result strobe, the operation register and
// the sequencer; cell contents are not cleared and need no clearing pass.
module sorted_byte_frequency_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sbft_pkg::item_t   item,
  output logic              result_valid,
  output sbft_pkg::result_t result
);
  import sbft_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_REDUCE,
    S_APPLY
  } state_t;

  state_t state;
  logic   req;
  sym_t   sym_reg;
  logic [7:0] ridx;
  fill_t  n;
  logic [NUM_SYMBOLS-1:0] match_reg;
  count_t c_reg;
  idx_t   pos_reg;
  op_t    op_reg;

  cell_cmd_t  cmd;
  sym_t       syms [NUM_SYMBOLS];
  count_t     cnts [NUM_SYMBOLS];
  cell_stat_t stats [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] occ;
  logic [NUM_SYMBOLS-1:0] match_vec;
  logic [NUM_SYMBOLS-1:0] run_end_vec;
  logic [NUM_SYMBOLS-1:0] ins_vec;
  logic [NUM_SYMBOLS-1:0] rank_hot;

  count_t m_cnt;
  idx_t   m_idx;
  idx_t   r_idx;
  logic   found;
  logic   read_hit;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.op = (state == S_APPLY) ? op_reg : OP_NONE;
    cmd.sym = sym_reg;
    cmd.c = c_reg;
    cmd.cnew = c_reg + COUNT_ONE;
  end

  for (genvar i = 0; i < NUM_SYMBOLS; i++) begin : g_cell
    logic   l_occ;
    sym_t   l_sym;
    count_t l_cnt;
    logic   r_occ;
    sym_t   r_sym;
    count_t r_cnt;
    logic   slot;
    logic   at_or_past;

    assign occ[i] = (N_W'(i) < n);
    assign slot = (N_W'(i) <= n);
    assign at_or_past = (IDX_W'(i) >= pos_reg);

    if (i == 0) begin : g_first
      assign l_occ = 1'b0;
      assign l_sym = '0;
      assign l_cnt = '0;
    end else begin : g_inner_l
      assign l_occ = occ[i-1];
      assign l_sym = syms[i-1];
      assign l_cnt = cnts[i-1];
    end

    if (i == NUM_SYMBOLS - 1) begin : g_last
      assign r_occ = 1'b0;
      assign r_sym = '0;
      assign r_cnt = '0;
    end else begin : g_inner_r
      assign r_occ = occ[i+1];
      assign r_sym = syms[i+1];
      assign r_cnt = cnts[i+1];
    end

    sbft_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ[i]),
      .slot       (slot),
      .at_or_past (at_or_past),
      .left_occ   (l_occ),
      .left_sym   (l_sym),
      .left_cnt   (l_cnt),
      .right_occ  (r_occ),
      .right_sym  (r_sym),
      .right_cnt  (r_cnt),
      .sym        (syms[i]),
      .cnt        (cnts[i]),
      .stat       (stats[i])
    );

    assign match_vec[i] = stats[i].match;
    assign run_end_vec[i] = stats[i].run_end;
    assign ins_vec[i] = stats[i].ins_here;
  end

  sbft_select u_match_sel (
    .hot     (match_reg),
    .syms    (syms),
    .cnts    (cnts),
    .sym_sel (),
    .cnt_sel (m_cnt),
    .idx_sel (m_idx)
  );

  // The final position is taken from the row before it shifts.
  assign rank_hot = (op_reg == OP_BUMP) ? run_end_vec : ins_vec;

  sbft_select u_rank_sel (
    .hot     (rank_hot),
    .syms    (syms),
    .cnts    (cnts),
    .sym_sel (),
    .cnt_sel (),
    .idx_sel (r_idx)
  );

  assign found = |match_reg;
  assign read_hit = ({1'b0, ridx} < 9'(n));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      result_valid <= 1'b0;
      op_reg <= OP_NONE;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req <= item.req_type;
            sym_reg <= item.symbol_in;
            ridx <= item.read_index;
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          match_reg <= match_vec;
          if (req == REQ_READ) begin
            result_valid <= 1'b1;
            result.rank_out <= ridx;
            result.distinct_out <= 9'(n);
            result.entry_valid <= read_hit;
            if (read_hit) begin
              result.symbol_out <= syms[ridx[IDX_W-1:0]];
              result.count_out <= to_count_out(cnts[ridx[IDX_W-1:0]]);
            end else begin
              result.symbol_out <= '0;
              result.count_out <= '0;
            end
            state <= S_IDLE;
          end else begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          c_reg <= m_cnt;
          pos_reg <= m_idx;
          result.symbol_out <= sym_reg;
          result.distinct_out <= 9'(n);
          if (found && (m_cnt == COUNT_MAX)) begin
            // Saturated count: the entry stays where it is.
            result_valid <= 1'b1;
            result.count_out <= to_count_out(m_cnt);
            result.rank_out <= 8'(m_idx);
            result.entry_valid <= 1'b1;
            state <= S_IDLE;
          end else if (!found && (n >= N_W'(NUM_SYMBOLS))) begin
            // No room left for a new symbol: the item is dropped.
            result_valid <= 1'b1;
            result.count_out <= '0;
            result.rank_out <= '0;
            result.entry_valid <= 1'b0;
            state <= S_IDLE;
          end else begin
            op_reg <= found ? OP_BUMP : OP_INSERT;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          result_valid <= 1'b1;
          result.rank_out <= 8'(r_idx);
          result.entry_valid <= 1'b1;
          if (op_reg == OP_BUMP) begin
            result.count_out <= to_count_out(cmd.cnew);
          end else begin
            result.count_out <= to_count_out(COUNT_ONE);
            result.distinct_out <= 9'(n + N_W'(1));
            n <= n + N_W'(1);
          end
          op_reg <= OP_NONE;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sbft_checker.sv =====
// ----------------------------------------------------------------------------
// sbft_checker: port-level checks for the sorted byte frequency table
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module sbft_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input sbft_pkg::result_t result
);
  import sbft_pkg::*;

  // An accepted item always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // An item is accepted only while idle and shows its result from a later state, so strobes never come back to back.
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("two result strobes in a row");

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // A valid entry implies the list holds at least one symbol.
  a_valid_nonempty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.entry_valid) |-> (result.distinct_out != 9'd0))
    else $error("valid entry reported from an empty list");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.entry_valid) |-> (result.count_out == 24'd0))
    else $error("invalid entry with a nonzero count");

endmodule

bind sorted_byte_frequency_table sbft_checker u_sbft_checker (.*);
